>>> sv/utf8tc_pkg.sv
// ----------------------------------------------------------------------------
// utf8tc_pkg
// Shared types, constants and helper functions of the UTF-8 text counter.
// ----------------------------------------------------------------------------
package utf8tc_pkg;

  localparam int unsigned COUNT_BITS = 48;
  localparam int unsigned OUT_BITS   = 48;
  localparam int unsigned CODE_BITS  = 21;
  localparam int unsigned LEN_BITS   = 3;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [OUT_BITS-1:0]   out_count_t;
  typedef logic [CODE_BITS-1:0]  code_t;
  typedef logic [LEN_BITS-1:0]   len_t;

  localparam count_t COUNT_MAX = '1;

  localparam len_t LEN_NONE = 3'd0;
  localparam len_t LEN_ONE  = 3'd1;
  localparam len_t LEN_TWO  = 3'd2;
  localparam len_t LEN_THREE = 3'd3;
  localparam len_t LEN_FOUR = 3'd4;

  localparam code_t CP_NEWLINE    = 21'h00000A;
  localparam code_t CP_MIN_TWO    = 21'h000080;
  localparam code_t CP_MIN_THREE  = 21'h000800;
  localparam code_t CP_MIN_FOUR   = 21'h010000;
  localparam code_t CP_MAX        = 21'h10FFFF;
  localparam code_t CP_SURR_LO    = 21'h00D800;
  localparam code_t CP_SURR_HI    = 21'h00DFFF;

  // one step of the decoder as seen by the counters
  typedef struct packed {
    logic  vld;
    code_t code;
  } char_t;

  // final counts of one text
  typedef struct packed {
    count_t lines;
    count_t words;
    count_t bytes;
    count_t chars;
  } counts_t;

  function automatic logic is_space(input code_t cp);
    logic sp;
    sp = (cp == 21'h20) || (cp >= 21'h09 && cp <= 21'h0D) ||
         (cp >= 21'h2000 && cp <= 21'h200A) ||
         (cp == 21'h85) || (cp == 21'hA0) || (cp == 21'h1680) ||
         (cp == 21'h2028) || (cp == 21'h2029) || (cp == 21'h202F) ||
         (cp == 21'h205F) || (cp == 21'h3000);
    return sp;
  endfunction

  function automatic count_t sat_inc(input count_t v);
    count_t r;
    r = (v == COUNT_MAX) ? v : v + count_t'(1);
    return r;
  endfunction

  function automatic out_count_t to_out(input count_t v);
    logic [63:0] wide;
    wide = 64'(v);
    return wide[OUT_BITS-1:0];
  endfunction

endpackage

>>> sv/utf8tc_decoder.sv
// ----------------------------------------------------------------------------
// utf8tc_decoder
// UTF-8 sequence assembler: holds the pending sequence and flags each whole,
// valid character with its code point.
// ----------------------------------------------------------------------------
module utf8tc_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 clear_i,
  input  logic [7:0]           data_byte_i,
  output utf8tc_pkg::char_t    char_o
);
  import utf8tc_pkg::*;

  code_t partial_q, partial_d;
  len_t  held_q, held_d;
  len_t  wanted_q, wanted_d;

  logic  is_cont;
  code_t shifted;
  len_t  held_inc;

  function automatic logic code_ok(input code_t cp, input len_t len);
    logic ok;
    unique case (len)
      LEN_TWO:   ok = cp >= CP_MIN_TWO;
      LEN_THREE: ok = cp >= CP_MIN_THREE && !(cp >= CP_SURR_LO && cp <= CP_SURR_HI);
      LEN_FOUR:  ok = cp >= CP_MIN_FOUR && cp <= CP_MAX;
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

  assign is_cont  = data_byte_i[7:6] == 2'b10;
  assign shifted  = {partial_q[CODE_BITS-7:0], data_byte_i[5:0]};
  assign held_inc = held_q + LEN_ONE;

  always_comb begin
    partial_d   = partial_q;
    held_d      = held_q;
    wanted_d    = wanted_q;
    char_o.vld  = 1'b0;
    char_o.code = shifted;
    if (step_i) begin
      if (held_q != LEN_NONE && is_cont) begin
        if (held_inc >= wanted_q) begin
          char_o.vld = code_ok(shifted, wanted_q);
          held_d     = LEN_NONE;
          partial_d  = '0;
        end else begin
          held_d    = held_inc;
          partial_d = shifted;
        end
      end else begin
        // fresh lead, also after a broken sequence
        held_d    = LEN_NONE;
        partial_d = '0;
        priority if (!data_byte_i[7]) begin
          char_o.vld  = 1'b1;
          char_o.code = code_t'(data_byte_i);
        end else if (data_byte_i[7:5] == 3'b110) begin
          partial_d = code_t'(data_byte_i[4:0]);
          wanted_d  = LEN_TWO;
          held_d    = LEN_ONE;
        end else if (data_byte_i[7:4] == 4'b1110) begin
          partial_d = code_t'(data_byte_i[3:0]);
          wanted_d  = LEN_THREE;
          held_d    = LEN_ONE;
        end else if (data_byte_i[7:3] == 5'b11110) begin
          partial_d = code_t'(data_byte_i[2:0]);
          wanted_d  = LEN_FOUR;
          held_d    = LEN_ONE;
        end else begin
          held_d = LEN_NONE;
        end
      end
      if (clear_i) begin
        partial_d = '0;
        held_d    = LEN_NONE;
        wanted_d  = LEN_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      held_q    <= LEN_NONE;
      wanted_q  <= LEN_NONE;
    end else begin
      partial_q <= partial_d;
      held_q    <= held_d;
      wanted_q  <= wanted_d;
    end
  end

  a_held_below_wanted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q != LEN_NONE |-> held_q < wanted_q)
    else $error("pending sequence already complete");

  a_wanted_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q != LEN_NONE |-> (wanted_q == LEN_TWO || wanted_q == LEN_THREE ||
                            wanted_q == LEN_FOUR))
    else $error("bad sequence length");

endmodule

>>> sv/utf8tc_counters.sv
// ----------------------------------------------------------------------------
// utf8tc_counters
// Saturating byte, line, word and character counters with word tracking.
// ----------------------------------------------------------------------------
module utf8tc_counters (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 clear_i,
  input  utf8tc_pkg::char_t    char_i,
  output utf8tc_pkg::counts_t  counts_o
);
  import utf8tc_pkg::*;

  counts_t cnt_q, cnt_d;
  logic    inside_q, inside_d;
  logic    space;

  assign space = is_space(char_i.code);

  always_comb begin
    cnt_d    = cnt_q;
    inside_d = inside_q;
    if (step_i) begin
      cnt_d.bytes = sat_inc(cnt_q.bytes);
      if (char_i.vld) begin
        cnt_d.chars = sat_inc(cnt_q.chars);
        if (char_i.code == CP_NEWLINE) begin
          cnt_d.lines = sat_inc(cnt_q.lines);
        end
        if (space) begin
          inside_d = 1'b0;
        end else if (!inside_q) begin
          inside_d    = 1'b1;
          cnt_d.words = sat_inc(cnt_q.words);
        end
      end
    end
  end

  // counts including the current byte
  assign counts_o = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      inside_q <= 1'b0;
    end else if (step_i && clear_i) begin
      cnt_q    <= '0;
      inside_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      inside_q <= inside_d;
    end
  end

endmodule

>>> sv/utf8_text_counter_core.sv
// ----------------------------------------------------------------------------
// utf8_text_counter_core
// Counts bytes, newlines, valid UTF-8 characters and words of a byte stream.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while in_ready_o is high. A byte passes
// an input register, then the decoder and counter update, and the final
// byte of a text loads the result register, so the four counts appear once
// it has passed both registers. in_ready_o drops only while a final byte
// waits in the input register behind a result that has not been taken.
module utf8_text_counter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          end_of_text_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output utf8tc_pkg::out_count_t        line_count_o,
  output utf8tc_pkg::out_count_t        word_count_o,
  output utf8tc_pkg::out_count_t        byte_count_o,
  output utf8tc_pkg::out_count_t        char_count_o
);
  import utf8tc_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eot_q;
  logic       out_vld_q;
  logic       step;
  logic       done;
  char_t      chr;
  counts_t    counts;
  out_count_t line_q, word_q, byte_q, char_q;

  assign step       = in_vld_q && (!in_eot_q || !out_vld_q || out_ready_i);
  assign done       = step && in_eot_q;
  assign in_ready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
      in_eot_q  <= end_of_text_i;
    end
  end

  utf8tc_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .clear_i     (in_eot_q),
    .data_byte_i (in_byte_q),
    .char_o      (chr)
  );

  utf8tc_counters u_counters (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .clear_i  (in_eot_q),
    .char_i   (chr),
    .counts_o (counts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (done) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      line_q <= to_out(counts.lines);
      word_q <= to_out(counts.words);
      byte_q <= to_out(counts.bytes);
      char_q <= to_out(counts.chars);
    end
  end

  assign out_valid_o  = out_vld_q;
  assign line_count_o = line_q;
  assign word_count_o = word_q;
  assign byte_count_o = byte_q;
  assign char_count_o = char_q;

  a_done_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_valid_o)
    else $error("final word did not produce a result");

  a_result_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> byte_count_o != '0)
    else $error("result with zero byte count");

  a_stall_only_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_eot_q && out_vld_q && !out_ready_i))
    else $error("input stalled without a pending result");

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of utf8_text_counter_core. Texts are streamed one byte per word,
// first a short directed set covering spaces, newlines, every sequence
// length and each kind of malformed input, then random texts built mostly
// from well-formed UTF-8 with noise, broken and out-of-range sequences mixed
// in. A scoreboard class predicts the four counts of every text and checks
// each result word in order. Both sides idle at random, and the receiver
// holds off once for a long stretch so that the block stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8tc_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1900;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_AT      = 4;
  localparam int unsigned DRAIN_CYCLES = 10;

  class utf8_tally;
    code_t       partial;
    len_t        held;
    len_t        wanted;
    bit          in_word;
    count_t      nl_cnt;
    count_t      word_cnt;
    count_t      byte_cnt;
    count_t      char_cnt;
    counts_t     pending[$];
    int unsigned errors;
    int unsigned texts;

    function new();
      errors = 0;
      texts  = 0;
      clear();
    endfunction

    function void clear();
      partial  = '0;
      held     = LEN_NONE;
      wanted   = LEN_NONE;
      in_word  = 1'b0;
      nl_cnt   = '0;
      word_cnt = '0;
      byte_cnt = '0;
      char_cnt = '0;
    endfunction

    function count_t bump(count_t v);
      return (v == COUNT_MAX) ? v : v + count_t'(1);
    endfunction

    function bit blank(code_t cp);
      return (cp >= 21'h09 && cp <= 21'h0D) || cp == 21'h20 || cp == 21'h85 ||
             cp == 21'hA0 || cp == 21'h1680 || (cp >= 21'h2000 && cp <= 21'h200A) ||
             cp == 21'h2028 || cp == 21'h2029 || cp == 21'h202F ||
             cp == 21'h205F || cp == 21'h3000;
    endfunction

    function void take_char(code_t cp);
      char_cnt = bump(char_cnt);
      if (cp == CP_NEWLINE) nl_cnt = bump(nl_cnt);
      if (blank(cp)) begin
        in_word = 1'b0;
      end else if (!in_word) begin
        in_word  = 1'b1;
        word_cnt = bump(word_cnt);
      end
    endfunction

    function bit legal(code_t cp, len_t n);
      case (n)
        LEN_TWO:   return cp >= CP_MIN_TWO;
        LEN_THREE: return cp >= CP_MIN_THREE && !(cp >= CP_SURR_LO && cp <= CP_SURR_HI);
        LEN_FOUR:  return cp >= CP_MIN_FOUR && cp <= CP_MAX;
        default:   return 1'b0;
      endcase
    endfunction

    function void open_seq(logic [7:0] b);
      if (b < 8'h80) begin
        take_char(code_t'(b));
      end else if (b >= 8'hC0 && b <= 8'hDF) begin
        partial = code_t'(b[4:0]);
        wanted  = LEN_TWO;
        held    = LEN_ONE;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        partial = code_t'(b[3:0]);
        wanted  = LEN_THREE;
        held    = LEN_ONE;
      end else if (b >= 8'hF0 && b <= 8'hF7) begin
        partial = code_t'(b[2:0]);
        wanted  = LEN_FOUR;
        held    = LEN_ONE;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      counts_t c;
      byte_cnt = bump(byte_cnt);
      if (held == LEN_NONE) begin
        open_seq(b);
      end else if (b[7:6] == 2'b10) begin
        partial = code_t'({partial, b[5:0]});
        held    = held + LEN_ONE;
        if (held >= wanted) begin
          if (legal(partial, wanted)) take_char(partial);
          held    = LEN_NONE;
          partial = '0;
        end
      end else begin
        held    = LEN_NONE;
        partial = '0;
        open_seq(b);
      end
      if (last) begin
        c.lines = nl_cnt;
        c.words = word_cnt;
        c.bytes = byte_cnt;
        c.chars = char_cnt;
        pending.push_back(c);
        texts++;
        clear();
      end
    endfunction

    function void cmp_field(string name, out_count_t exp_v, out_count_t act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_counts(out_count_t l, out_count_t w, out_count_t by,
                               out_count_t ch);
      counts_t c;
      if (pending.size() == 0) begin
        $error("count word with no text pending: lines %0d words %0d bytes %0d chars %0d",
               l, w, by, ch);
        errors++;
        return;
      end
      c = pending.pop_front();
      cmp_field("line_count", out_count_t'(c.lines), l);
      cmp_field("word_count", out_count_t'(c.words), w);
      cmp_field("byte_count", out_count_t'(c.bytes), by);
      cmp_field("char_count", out_count_t'(c.chars), ch);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_ni;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       end_of_text;
  logic       out_valid;
  logic       out_ready;
  out_count_t line_count;
  out_count_t word_count;
  out_count_t byte_count;
  out_count_t char_count;

  utf8_tally   tally;
  logic [7:0]  text_q[$];
  bit          tx_calm;
  bit          rx_calm;
  int unsigned bytes_sent;
  int unsigned sets_taken;
  int unsigned idle_cycles;

  always #5ns clk = ~clk;

  utf8_text_counter_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .data_byte_i   (data_byte),
    .end_of_text_i (end_of_text),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .line_count_o  (line_count),
    .word_count_o  (word_count),
    .byte_count_o  (byte_count),
    .char_count_o  (char_count)
  );

  // encode cp into exactly n bytes, whether or not that length is proper
  function automatic void push_coded(int unsigned cp, int unsigned n);
    logic [20:0] c;
    c = cp[20:0];
    case (n)
      1: text_q.push_back({1'b0, c[6:0]});
      2: begin
        text_q.push_back({3'b110, c[10:6]});
        text_q.push_back({2'b10, c[5:0]});
      end
      3: begin
        text_q.push_back({4'b1110, c[15:12]});
        text_q.push_back({2'b10, c[11:6]});
        text_q.push_back({2'b10, c[5:0]});
      end
      default: begin
        text_q.push_back({5'b11110, c[20:18]});
        text_q.push_back({2'b10, c[17:12]});
        text_q.push_back({2'b10, c[11:6]});
        text_q.push_back({2'b10, c[5:0]});
      end
    endcase
  endfunction

  function automatic void add_element();
    int unsigned pick;
    int unsigned n;
    int unsigned cp;
    int unsigned uspace[8];
    uspace = '{32'h85, 32'hA0, 32'h1680, 32'h2000, 32'h2028, 32'h205F, 32'h202F,
               32'h3000};
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      push_coded($urandom_range(8'h21, 8'h7E), 1);
    end else if (pick < 40) begin
      case ($urandom_range(0, 3))
        0: push_coded(8'h20, 1);
        1: push_coded(8'h0A, 1);
        default: push_coded($urandom_range(8'h09, 8'h0D), 1);
      endcase
    end else if (pick < 45) begin
      push_coded($urandom_range(0, 8'h7F), 1);
    end else if (pick < 60) begin
      push_coded($urandom_range(32'h80, 32'h7FF), 2);
    end else if (pick < 72) begin
      push_coded($urandom_range(32'h800, 32'hFFFF), 3);
    end else if (pick < 80) begin
      push_coded($urandom_range(32'h10000, 32'h10FFFF), 4);
    end else if (pick < 88) begin
      cp = uspace[$urandom_range(0, 7)];
      if (cp == 32'h2000) cp = cp + $urandom_range(0, 10);
      if (cp == 32'h2028) cp = cp + $urandom_range(0, 1);
      push_coded(cp, (cp < 32'h800) ? 2 : 3);
    end else if (pick < 92) begin
      text_q.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 96) begin
      n = $urandom_range(2, 4);
      push_coded($urandom_range(0, 32'h1FFFFF), n);
      repeat ($urandom_range(1, n - 1)) void'(text_q.pop_back());
    end else if (pick < 98) begin
      n  = $urandom_range(2, 4);
      cp = (n == 2) ? 32'h80 : (n == 3) ? 32'h800 : 32'h10000;
      push_coded($urandom_range(0, cp - 1), n);
    end else begin
      push_coded($urandom_range(32'h110000, 32'h1FFFFF), 4);
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    end_of_text <= last;
    do @(posedge clk); while (!in_ready);
    tally.note_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
  endtask

  task automatic send_directed();
    // word, space, newline, nbsp, nul, 4-byte char, stray high byte
    text_q = '{8'h61, 8'h20, 8'h0A, 8'hC2, 8'hA0, 8'h00, 8'hF0, 8'h9F, 8'h98, 8'h80,
               8'hFF};
    send_text();
    // stray continuation, overlong, surrogate, broken lead, unfinished at end
    text_q = '{8'h80, 8'hC1, 8'hBF, 8'hED, 8'hA0, 8'h80, 8'hE2, 8'h41, 8'hE2, 8'h82};
    send_text();
    // above the top code point
    text_q = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_text();
  endtask

  task automatic send_random();
    int unsigned n;
    while (bytes_sent < RANDOM_BYTES) begin
      text_q.delete();
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 30);
      repeat (n) add_element();
      tx_calm = ($urandom_range(0, 3) == 0);
      send_text();
    end
  endtask

  // receiver side
  initial begin
    int unsigned stall;
    bit          held_off;
    out_ready  = 1'b0;
    sets_taken = 0;
    held_off   = 1'b0;
    rx_calm    = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk);
    forever begin
      if (sets_taken == HOLD_AT && !held_off) begin
        held_off  = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = rx_calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      tally.check_counts(line_count, word_count, byte_count, char_count);
      sets_taken++;
      rx_calm = ($urandom_range(0, 4) == 0);
      @(negedge clk);
    end
  end

  // watchdog on cycles with no word moving
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("utf8_text_counter_core: mismatch");
    $finish;
  end

  initial begin
    tally       = new();
    bytes_sent  = 0;
    tx_calm     = 1'b0;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    data_byte   = 8'h00;
    end_of_text = 1'b0;
    repeat (12) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);
    send_directed();
    send_random();
    in_valid <= 1'b0;
    while (tally.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("streamed %0d bytes in %0d texts, %0d count words checked",
             bytes_sent, tally.texts, sets_taken);
    $display("malformed, overlong, surrogate and unfinished sequences mixed with valid text");
    if (tally.errors == 0) begin
      $display("utf8_text_counter_core: match");
    end else begin
      $display("utf8_text_counter_core: mismatch");
    end
    $finish;
  end

endmodule

>>> utf8_text_counter_core.f
sv/utf8tc_pkg.sv
sv/utf8tc_decoder.sv
sv/utf8tc_counters.sv
sv/utf8_text_counter_core.sv
sim/tb_top.sv
